FILE: rtl/ddo_pkg.sv
package ddo_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_TRACK    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT = 1'b1;

    localparam logic [22:0] TRACK_RESET = 23'd1553203;
    localparam logic [23:0] DPC_RESET   = 24'd1450850;

    localparam logic signed [31:0] PI_Q      = 32'sd1686629713;
    localparam logic signed [33:0] PI_Q34    = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI_Q  = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd843314857;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd326016437;
    localparam logic [31:0] ONE_Q29 = 32'd536870912;

    localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_L, S_MUL_R, S_TRV_R, S_DIFF, S_ANG, S_DIVA,
        S_CH_GO, S_CH_WAIT, S_CN_GO, S_CN_WAIT,
        S_RX_GO, S_RX_WAIT, S_RY_GO, S_RY_WAIT,
        S_MX_LO, S_MX_HI, S_MY_LO, S_MY_HI, S_MY_ACC, S_DY,
        S_ABS, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT_WAIT, S_OUT
    } ddo_state_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quo;
    } ddo_div_res_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } ddo_cordic_res_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } ddo_sqrt_res_t;

    function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0:  r = 34'sd421657428;
            5'd1:  r = 34'sd248918914;
            5'd2:  r = 34'sd131521918;
            5'd3:  r = 34'sd66762579;
            5'd4:  r = 34'sd33510843;
            5'd5:  r = 34'sd16771758;
            5'd6:  r = 34'sd8387925;
            5'd7:  r = 34'sd4194219;
            5'd8:  r = 34'sd2097141;
            5'd9:  r = 34'sd1048575;
            5'd30: r = 34'sd0;
            5'd31: r = 34'sd0;
            default: r = 34'sd1 <<< (5'd29 - i);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ddo_divider.sv
module ddo_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [63:0]          num,
    input  logic [31:0]          den,
    output ddo_pkg::ddo_div_res_t res
);
    import ddo_pkg::*;

    logic [31:0] rem_reg;
    logic [31:0] lo_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, lo_reg[31]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[63:32];
            lo_reg  <= num[31:0];
            den_reg <= den;
            ovf_reg <= num[63:32] >= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            lo_reg  <= {lo_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;
endmodule

FILE: rtl/ddo_cordic.sv
module ddo_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [33:0]      ang,
    output ddo_pkg::ddo_cordic_res_t res
);
    import ddo_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] xs, ys, at;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               flip_reg;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = atan_q29(5'(cnt_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // fold into the right half plane, then rotate one micro-step a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            if (ang > HALF_PI_Q) begin
                z_reg    <= ang - PI_Q34;
                flip_reg <= 1'b1;
            end else if (ang < -HALF_PI_Q) begin
                z_reg    <= ang + PI_Q34;
                flip_reg <= 1'b1;
            end else begin
                z_reg    <= ang;
                flip_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign res.done  = done_reg;
    assign res.cos_v = flip_reg ? -x_reg : x_reg;
    assign res.sin_v = flip_reg ? -y_reg : y_reg;
endmodule

FILE: rtl/ddo_sqrt.sv
module ddo_sqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [63:0]           rad,
    output ddo_pkg::ddo_sqrt_res_t res
);
    import ddo_pkg::*;

    logic [33:0] rem_reg;
    logic [63:0] src_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] r2;
    logic [35:0] trial;
    logic        fits;

    assign r2    = {rem_reg, src_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = r2 >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one root bit a cycle from two radicand bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            src_reg  <= rad;
            root_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? 34'(r2 - trial) : r2[33:0];
            src_reg  <= {src_reg[61:0], 2'b00};
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.root = root_reg;
endmodule

FILE: rtl/differential_drive_odometry.sv
// Dead-reckoning odometry for a two-wheel robot.
// Input channel (s_valid/s_ready): one word holds the two absolute encoder
// counts. Result channel (m_valid/m_ready): one word per input word with the
// saturated x and y position, the heading in Q3.29 and the step length.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the wheel track or the
// travel per count, one per write; write them only while the block is idle.
// Each word runs through one shared 33x33 multiplier, an iterative divider
// (one quotient bit a cycle), an iterative CORDIC (one micro-rotation a cycle)
// and an iterative square root (one root bit a cycle), under one sequencer.
// The divider passes (three when the heading changes, one on a straight step),
// the CORDIC runs (two, or one on a straight step) and the root dominate the
// time per word. s_ready is high only when the sequencer is idle, so the block
// takes a new word only once the sequencer is done with the last one.
// A finished result sits in the output register; the next word is accepted
// while it waits, but the sequencer holds in its last step until the
// receiver takes it, so a stalled receiver stalls the block.
// Reset (aresetn, synchronous, active low) clears the pose, the last counts
// and the handshakes and loads the register defaults.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_left_count,
    input  logic signed [31:0]                s_right_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [39:0]                m_x_pos,
    output logic signed [39:0]                m_y_pos,
    output logic signed [31:0]                m_heading,
    output logic [31:0]                       m_step_length
);
    import ddo_pkg::*;

    ddo_state_t state_reg, state_next;

    // configuration
    logic [22:0] track_reg;
    logic [23:0] dpc_reg;

    // pose and previous counts
    logic [31:0]        last_l_reg, last_r_reg;
    logic signed [31:0] head_reg;
    logic signed [39:0] x_reg, y_reg;

    // per-word working registers
    logic [31:0]        cl_reg, cr_reg;
    logic signed [39:0] dl_reg, dr_reg;
    logic signed [40:0] diff_reg, sum_reg;
    logic               big_reg;
    logic signed [31:0] da_reg, n_reg;
    logic signed [33:0] ch_reg, sh_reg, cn_reg, sn_reg;
    logic               rneg_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [73:0] acc_reg;
    logic signed [43:0] dx_reg, dy_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic               st_sat_reg;

    // output register
    logic               m_valid_reg;
    logic signed [39:0] m_x_reg, m_y_reg;
    logic signed [31:0] m_head_reg;
    logic [31:0]        m_step_reg;

    // shared multiplier
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] p_reg;

    // unit hookup
    logic               div_start;
    logic [63:0]        div_num;
    logic [31:0]        div_den;
    ddo_div_res_t       div_res;
    logic               cor_start;
    logic signed [33:0] cor_ang;
    ddo_cordic_res_t    cor_res;
    logic               sq_start;
    ddo_sqrt_res_t      sq_res;

    // combinational helpers
    logic [31:0]        dcl, dcr;
    logic signed [65:0] trv_rnd;
    logic signed [39:0] trv;
    logic [40:0]        dm;
    logic [22:0]        track_eff;
    logic [31:0]        q_turn;
    logic signed [33:0] n_sum, n_wrap;
    logic signed [33:0] c_diff;
    logic [33:0]        cm;
    logic [31:0]        da_mag;
    logic [31:0]        q_ratio;
    logic signed [31:0] r_signed;
    logic signed [73:0] acc_rnd;
    logic signed [43:0] rnd30;
    logic [43:0]        ax_full, ay_full;
    logic [64:0]        sq_sum;
    logic signed [39:0] x_new, y_new;
    logic               out_load;

    function automatic logic signed [39:0] sat_pos(input logic signed [65:0] v);
        logic signed [39:0] r;
        if (v > 66'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < 66'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    ddo_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .res    (div_res)
    );

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cor_start),
        .ang    (cor_ang),
        .res    (cor_res)
    );

    ddo_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .rad    (sq_sum[63:0]),
        .res    (sq_res)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_x_pos       = m_x_reg;
    assign m_y_pos       = m_y_reg;
    assign m_heading     = m_head_reg;
    assign m_step_length = m_step_reg;

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // travel: wrap the count delta, scale, round and saturate
    assign dcl     = cl_reg - last_l_reg;
    assign dcr     = cr_reg - last_r_reg;
    assign trv_rnd = p_reg + 66'sd128;
    assign trv     = sat_pos(66'($signed(trv_rnd[65:8])));

    // heading change numerator; a zero track acts as one LSB
    assign dm        = diff_reg[40] ? 41'(-diff_reg) : 41'(diff_reg);
    assign track_eff = (track_reg == '0) ? 23'd1 : track_reg;
    assign q_turn    = (big_reg || div_res.ovf || (div_res.quo > 32'(PI_Q)))
                       ? 32'(PI_Q) : div_res.quo;

    // new heading, wrapped once
    assign n_sum  = 34'(head_reg) + 34'(da_reg);
    assign n_wrap = (n_sum > PI_Q34)  ? n_sum - TWO_PI_Q :
                    (n_sum < -PI_Q34) ? n_sum + TWO_PI_Q : n_sum;

    // arc factors
    assign c_diff   = (state_reg == S_RX_GO) ? ch_reg - cn_reg : sn_reg - sh_reg;
    assign cm       = c_diff[33] ? 34'(-c_diff) : 34'(c_diff);
    assign da_mag   = da_reg[31] ? 32'(-da_reg) : 32'(da_reg);
    assign q_ratio  = (div_res.ovf || (div_res.quo > ONE_Q29)) ? ONE_Q29 : div_res.quo;
    assign r_signed = rneg_reg ? -$signed(q_ratio) : $signed(q_ratio);

    // round half up after the Q30 product
    assign acc_rnd = acc_reg + 74'sd536870912;
    assign rnd30   = $signed(acc_rnd[73:30]);

    assign ax_full = dx_reg[43] ? 44'(-dx_reg) : 44'(dx_reg);
    assign ay_full = dy_reg[43] ? 44'(-dy_reg) : 44'(dy_reg);
    assign sq_sum  = {1'b0, acc_reg[63:0]} + {1'b0, p_reg[63:0]};

    assign x_new = sat_pos(66'(x_reg) + 66'(dx_reg));
    assign y_new = sat_pos(66'(y_reg) + 66'(dy_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_MUL_L;
            S_MUL_L:     state_next = S_MUL_R;
            S_MUL_R:     state_next = S_TRV_R;
            S_TRV_R:     state_next = S_DIFF;
            S_DIFF:      state_next = S_ANG;
            S_ANG:       state_next = S_DIVA;
            S_DIVA:      if (div_res.done) state_next = S_CH_GO;
            S_CH_GO:     state_next = S_CH_WAIT;
            S_CH_WAIT: begin
                if (cor_res.done) begin
                    state_next = (da_reg == '0) ? S_MX_LO : S_CN_GO;
                end
            end
            S_CN_GO:     state_next = S_CN_WAIT;
            S_CN_WAIT:   if (cor_res.done) state_next = S_RX_GO;
            S_RX_GO:     state_next = S_RX_WAIT;
            S_RX_WAIT:   if (div_res.done) state_next = S_RY_GO;
            S_RY_GO:     state_next = S_RY_WAIT;
            S_RY_WAIT:   if (div_res.done) state_next = S_MX_LO;
            S_MX_LO:     state_next = S_MX_HI;
            S_MX_HI:     state_next = S_MY_LO;
            S_MY_LO:     state_next = S_MY_HI;
            S_MY_HI:     state_next = S_MY_ACC;
            S_MY_ACC:    state_next = S_DY;
            S_DY:        state_next = S_ABS;
            S_ABS:       state_next = S_SQ_X;
            S_SQ_X:      state_next = S_SQ_Y;
            S_SQ_Y:      state_next = S_SQ_SUM;
            S_SQ_SUM:    state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sq_res.done) state_next = S_OUT;
            S_OUT:       if (out_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // unit controls and multiplier operands
    always_comb begin
        op_a      = '0;
        op_b      = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        cor_start = 1'b0;
        cor_ang   = '0;
        sq_start  = 1'b0;
        unique case (state_reg)
            S_MUL_L: begin
                op_a = 33'($signed(dcl));
                op_b = $signed({9'b0, dpc_reg});
            end
            S_MUL_R: begin
                op_a = 33'($signed(dcr));
                op_b = $signed({9'b0, dpc_reg});
            end
            S_ANG: begin
                div_start = 1'b1;
                div_num   = {1'b0, dm[33:0], 29'b0} + 64'(track_eff[22:1]);
                div_den   = 32'(track_eff);
            end
            S_CH_GO: begin
                cor_start = 1'b1;
                cor_ang   = 34'(head_reg);
            end
            S_CN_GO: begin
                cor_start = 1'b1;
                cor_ang   = 34'(n_reg);
            end
            S_RX_GO, S_RY_GO: begin
                div_start = 1'b1;
                div_num   = {1'b0, cm, 29'b0} + 64'(da_mag[31:1]);
                div_den   = da_mag;
            end
            S_MX_LO: begin
                op_a = $signed({12'b0, sum_reg[20:0]});
                op_b = 33'(rx_reg);
            end
            S_MX_HI: begin
                op_a = 33'($signed(sum_reg[40:21]));
                op_b = 33'(rx_reg);
            end
            S_MY_LO: begin
                op_a = $signed({12'b0, sum_reg[20:0]});
                op_b = 33'(ry_reg);
            end
            S_MY_HI: begin
                op_a = 33'($signed(sum_reg[40:21]));
                op_b = 33'(ry_reg);
            end
            S_SQ_X: begin
                op_a = $signed({1'b0, ax_reg});
                op_b = $signed({1'b0, ax_reg});
            end
            S_SQ_Y: begin
                op_a = $signed({1'b0, ay_reg});
                op_b = $signed({1'b0, ay_reg});
            end
            S_SQ_SUM: sq_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg <= TRACK_RESET;
            dpc_reg   <= DPC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WHEEL_TRACK:    track_reg <= cfg_data[22:0];
                REG_DIST_PER_COUNT: dpc_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // pose, committed when the result word is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_l_reg <= '0;
            last_r_reg <= '0;
            head_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
        end else if (out_load) begin
            last_l_reg <= cl_reg;
            last_r_reg <= cr_reg;
            x_reg      <= x_new;
            y_reg      <= y_new;
            if (da_reg != '0) begin
                head_reg <= n_reg;
            end
        end
    end

    // output register: load on completion, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_x_reg    <= x_new;
            m_y_reg    <= y_new;
            m_head_reg <= (da_reg != '0) ? n_reg : head_reg;
            m_step_reg <= st_sat_reg ? 32'hFFFF_FFFF : sq_res.root;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        p_reg <= op_a * op_b;
        unique case (state_reg)
            S_IDLE: begin
                cl_reg <= s_left_count;
                cr_reg <= s_right_count;
            end
            S_MUL_R: dl_reg <= trv;
            S_TRV_R: dr_reg <= trv;
            S_DIFF: begin
                diff_reg <= 41'(dl_reg) - 41'(dr_reg);
                sum_reg  <= 41'(dl_reg) + 41'(dr_reg);
            end
            S_ANG: big_reg <= |dm[40:34];
            S_DIVA: begin
                if (div_res.done) begin
                    da_reg <= diff_reg[40] ? -$signed(q_turn) : $signed(q_turn);
                end
            end
            S_CH_GO: n_reg <= n_wrap[31:0];
            S_CH_WAIT: begin
                if (cor_res.done) begin
                    ch_reg <= cor_res.cos_v;
                    sh_reg <= cor_res.sin_v;
                    rx_reg <= cor_res.sin_v[31:0];
                    ry_reg <= cor_res.cos_v[31:0];
                end
            end
            S_CN_WAIT: begin
                if (cor_res.done) begin
                    cn_reg <= cor_res.cos_v;
                    sn_reg <= cor_res.sin_v;
                end
            end
            S_RX_GO, S_RY_GO: rneg_reg <= c_diff[33] ^ da_reg[31];
            S_RX_WAIT: if (div_res.done) rx_reg <= r_signed;
            S_RY_WAIT: if (div_res.done) ry_reg <= r_signed;
            S_MX_HI:  acc_reg <= 74'(p_reg);
            S_MY_LO:  acc_reg <= acc_reg + (74'(p_reg) <<< 21);
            S_MY_HI: begin
                dx_reg  <= rnd30;
                acc_reg <= 74'(p_reg);
            end
            S_MY_ACC: acc_reg <= acc_reg + (74'(p_reg) <<< 21);
            S_DY:     dy_reg  <= rnd30;
            S_ABS: begin
                ax_reg     <= ax_full[31:0];
                ay_reg     <= ay_full[31:0];
                st_sat_reg <= (|ax_full[43:32]) || (|ay_full[43:32]);
            end
            S_SQ_Y:   acc_reg <= 74'(p_reg);
            S_SQ_SUM: st_sat_reg <= st_sat_reg || sq_sum[64];
            default: ;
        endcase
    end
endmodule

FILE: rtl/ddo_checker.sv
module ddo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [39:0] m_x_pos,
    input logic signed [31:0] m_heading
);
    import ddo_pkg::*;

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_pos) && $stable(m_heading))
        else $error("result word changed while stalled");

    // the sequencer is busy right after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // heading stays wrapped
    a_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading <= PI_Q) && (m_heading >= -PI_Q))
        else $error("heading out of range");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_x_pos  (m_x_pos),
    .m_heading(m_heading)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ddo_pkg::*;

    localparam int  STEPS     = 24;
    localparam int  N_RANDOM  = 640;
    localparam longint LIMIT  = 2_000_000;
    localparam longint P_MAX  = 64'sd549755813887;
    localparam longint P_MIN  = -64'sd549755813888;
    localparam longint PI_V   = 64'sd1686629713;
    localparam longint HALF_V = 64'sd843314857;
    localparam longint GAIN_V = 64'sd326016437;
    localparam longint ONE_V  = 64'sd536870912;

    typedef struct packed {
        logic [39:0] x;
        logic [39:0] y;
        logic [31:0] hdg;
        logic [31:0] len;
    } pose_t;

    // One row of the directed table: either a register write or an input word,
    // with a typed-in result where it is obvious.
    typedef struct {
        bit          is_reg;
        bit [31:0]   a;
        bit [31:0]   b;
        bit          typed;
        pose_t       want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_left_count = '0;
    logic signed [31:0] s_right_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [39:0] m_x_pos;
    logic signed [39:0] m_y_pos;
    logic signed [31:0] m_heading;
    logic [31:0] m_step_length;

    differential_drive_odometry #(.CORDIC_STEPS(STEPS)) dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor copy of the pose, the last counts and the two registers.
    bit [31:0] last_l, last_r;
    longint    hdg_q, pos_x, pos_y;
    bit [22:0] track_reg;
    bit [23:0] dpc_reg;

    pose_t  pose_q[$];
    int     errors = 0;
    longint cycles = 0;
    bit     rx_busy = 1'b1;

    const longint atan_tab[32] = '{
        421657428, 248918914, 131521918, 66762579, 33510843, 16771758, 8387925,
        4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0};

    function automatic longint clamp40(input longint v);
        if (v > P_MAX) return P_MAX;
        if (v < P_MIN) return P_MIN;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Rotation-mode CORDIC, folding the outer half turns back in first.
    task automatic sincos(input longint ang, output longint c, output longint s);
        bit flip;
        longint x, y, z, xs, ys;
        flip = 1'b0;
        x = GAIN_V;
        y = 0;
        if (ang > HALF_V) begin
            ang -= PI_V;
            flip = 1'b1;
        end else if (ang < -HALF_V) begin
            ang += PI_V;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint scale30(input longint s, input longint r);
        longint rh, rl, hi, lo, q1, rem;
        rh = r >>> 15;
        rl = r - rh * 32768;
        hi = s * rh;
        lo = s * rl;
        q1 = hi >>> 15;
        rem = hi - q1 * 32768;
        return q1 + ((rem * 32768 + lo + (64'sd1 << 29)) >>> 30);
    endfunction

    function automatic longint ratio29(input longint c, input longint da);
        longint unsigned cm, dm, q;
        cm = magn(c);
        dm = magn(da);
        q = ((cm << 29) + dm / 2) / dm;
        if (q > 64'(ONE_V)) q = 64'(ONE_V);
        return ((c < 0) != (da < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint wheel_travel(input bit [31:0] now, input bit [31:0] prev);
        bit [31:0] du;
        longint d;
        du = now - prev;
        d = longint'($signed(du));
        return clamp40((d * longint'(dpc_reg) + 128) >>> 8);
    endfunction

    // Advance the predicted pose by one pair of counts.
    task automatic odometry_advance(input bit [31:0] cl, input bit [31:0] cr,
                                    output pose_t p);
        longint dl, dr, diff, sum, da, rx, ry, dx, dy, ch, sh, n, cn, sn;
        longint unsigned trk, dm, q, ax, ay, st, aa, bb;
        dl = wheel_travel(cl, last_l);
        dr = wheel_travel(cr, last_r);
        diff = dl - dr;
        sum = dl + dr;
        trk = track_reg != 0 ? 64'(track_reg) : 64'd1;
        dm = magn(diff);
        if (dm >= (64'd1 << 34)) q = 64'(PI_V);
        else q = ((dm << 29) + trk / 2) / trk;
        if (q > 64'(PI_V)) q = 64'(PI_V);
        da = diff < 0 ? -longint'(q) : longint'(q);
        sincos(hdg_q, ch, sh);
        if (da != 0) begin
            n = hdg_q + da;
            if (n > PI_V) n -= 2 * PI_V;
            else if (n < -PI_V) n += 2 * PI_V;
            sincos(n, cn, sn);
            rx = ratio29(ch - cn, da);
            ry = ratio29(sn - sh, da);
            hdg_q = n;
        end else begin
            // straight: sine drives x, cosine drives y
            rx = sh;
            ry = ch;
        end
        dx = scale30(sum, rx);
        dy = scale30(sum, ry);
        pos_x = clamp40(pos_x + dx);
        pos_y = clamp40(pos_y + dy);
        ax = magn(dx);
        ay = magn(dy);
        if (ax >= (64'd1 << 32) || ay >= (64'd1 << 32)) begin
            st = 64'hFFFF_FFFF;
        end else begin
            aa = ax * ax;
            bb = ay * ay;
            if (aa > ~64'd0 - bb) st = 64'hFFFF_FFFF;
            else st = root64(aa + bb);
            if (st > 64'hFFFF_FFFF) st = 64'hFFFF_FFFF;
        end
        last_l = cl;
        last_r = cr;
        p.x = pos_x[39:0];
        p.y = pos_y[39:0];
        p.hdg = hdg_q[31:0];
        p.len = st[31:0];
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Cycle budget; also the only way a hung block ends the run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Check each result word against the oldest predicted pose.
    always @(posedge aclk) begin
        pose_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pose_q.size() == 0) begin
                report("unexpected word", m_x_pos, 0);
            end else begin
                w = pose_q.pop_front();
                if (m_x_pos !== w.x) report("x_pos", m_x_pos, $signed(w.x));
                if (m_y_pos !== w.y) report("y_pos", m_y_pos, $signed(w.y));
                if (m_heading !== w.hdg) report("heading", m_heading, $signed(w.hdg));
                if (m_step_length !== w.len) report("step_length", m_step_length, w.len);
            end
        end
    end

    // Receiver back-pressure: mostly short stalls, now and then a long one,
    // with stretches of steady acceptance.
    initial begin
        int r;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!rx_busy) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) m_ready <= 1'b1;
                else if (r < 97) m_ready <= 1'b0;
                else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(20, 200)) @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return;
        if (r < 95) repeat ($urandom_range(1, 4)) @(negedge aclk);
        else repeat ($urandom_range(20, 250)) @(negedge aclk);
    endtask

    // Present one word at the falling edge and hold it until taken.
    task automatic send_counts(input bit [31:0] l, input bit [31:0] r, output pose_t p);
        s_valid <= 1'b1;
        s_left_count <= l;
        s_right_count <= r;
        do @(posedge aclk); while (!s_ready);
        odometry_advance(l, r, p);
        pose_q.push_back(p);
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Let the block drain, then write a register at the falling edge.
    task automatic wait_drained();
        while (pose_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_WHEEL_TRACK) track_reg = val[22:0];
        else dpc_reg = val;
        @(negedge aclk);
    endtask

    row_t rows[$];
    bit [31:0] gen_l, gen_r;

    function automatic row_t word_row(input bit [31:0] a, input bit [31:0] b);
        row_t t;
        t.is_reg = 1'b0;
        t.a = a;
        t.b = b;
        t.typed = 1'b0;
        return t;
    endfunction

    function automatic row_t reg_row(input bit [31:0] idx, input bit [31:0] val);
        row_t t;
        t = word_row(idx, val);
        t.is_reg = 1'b1;
        return t;
    endfunction

    initial begin
        pose_t p;
        row_t  t;
        int    mode, d1, d2;

        last_l = '0;
        last_r = '0;
        hdg_q = 0;
        pos_x = 0;
        pos_y = 0;
        track_reg = TRACK_RESET;
        dpc_reg = DPC_RESET;

        // Directed table. No motion at all from reset leaves the pose at zero.
        t = word_row(32'd0, 32'd0);
        t.typed = 1'b1;
        t.want = '{x: '0, y: '0, hdg: '0, len: '0};
        rows.push_back(t);
        rows.push_back(word_row(32'd1000, 32'd1000));          // straight ahead
        rows.push_back(word_row(32'd2000, 32'd1000));          // turn right
        rows.push_back(word_row(32'd1000, 32'd2000));          // turn left
        rows.push_back(word_row(32'd1000, 32'd2001));          // right wheel moves by one count
        rows.push_back(word_row(32'h7FFF_FFFF, 32'h7FFF_FFFF)); // travel saturates
        rows.push_back(word_row(32'h8000_0000, 32'h8000_0000)); // counter wraps by one
        rows.push_back(word_row(32'hFFFF_FFFF, 32'hFFFF_FFFF)); // long step forwards
        rows.push_back(word_row(32'h7FFF_FFFF, 32'h7FFF_FFFF)); // position saturates
        rows.push_back(word_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(word_row(32'h4000_0000, 32'hC000_0000)); // turn limited to pi
        rows.push_back(word_row(32'h4000_1000, 32'hC000_0000)); // heading wraps
        rows.push_back(word_row(32'h4000_1000, 32'hC000_0000)); // stand still
        rows.push_back(reg_row(REG_WHEEL_TRACK, 0));           // zero track as one LSB
        rows.push_back(reg_row(REG_DIST_PER_COUNT, 24'hFF_FFFF));
        rows.push_back(word_row(32'h4000_1001, 32'hC000_0000));
        rows.push_back(word_row(32'h4000_1001, 32'hC000_0005));
        rows.push_back(word_row(32'h0000_0000, 32'h5555_5555));
        rows.push_back(reg_row(REG_WHEEL_TRACK, 23'h7F_FFFF));
        rows.push_back(reg_row(REG_DIST_PER_COUNT, 1));
        rows.push_back(word_row(32'h0000_0001, 32'h5555_5555));
        rows.push_back(word_row(32'hAAAA_AAAA, 32'h0000_0000));

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                wait_drained();
                write_reg(rows[i].a[CFG_IDX_W-1:0], rows[i].b[23:0]);
            end else begin
                send_counts(rows[i].a, rows[i].b, p);
                if (rows[i].typed && p != rows[i].want)
                    report("typed row", i, 0);
                idle_gap();
            end
        end

        gen_l = last_l;
        gen_r = last_r;
        for (int n = 0; n < N_RANDOM; n++) begin
            // change settings at phase boundaries, extremes among them
            if (n % 160 == 0) begin
                wait_drained();
                case (n / 160)
                    0: begin
                        write_reg(REG_WHEEL_TRACK, TRACK_RESET);
                        write_reg(REG_DIST_PER_COUNT, DPC_RESET);
                    end
                    1: begin
                        write_reg(REG_WHEEL_TRACK, 23'd65536);
                        write_reg(REG_DIST_PER_COUNT, 24'hFF_FFFF);
                    end
                    2: begin
                        write_reg(REG_WHEEL_TRACK, 23'h7F_FFFF);
                        write_reg(REG_DIST_PER_COUNT, 24'd1);
                    end
                    default: begin
                        write_reg(REG_WHEEL_TRACK, 24'($urandom_range(65536, 23'h7F_FFFF)));
                        write_reg(REG_DIST_PER_COUNT, 24'($urandom_range(1, 24'hFF_FFFF)));
                    end
                endcase
            end
            // hold off once until the block has nothing outstanding
            if (n == 300) while (pose_q.size() != 0) @(negedge aclk);
            rx_busy = !(n >= 400 && n < 440);
            mode = $urandom_range(0, 99);
            d1 = int'($urandom_range(0, 4000)) - 2000;
            d2 = int'($urandom_range(0, 4000)) - 2000;
            if (mode < 35) begin
                gen_l += d1;
                gen_r += d1;
            end else if (mode < 80) begin
                gen_l += d1;
                gen_r += d2;
            end else if (mode < 90) begin
                gen_l += 32'($urandom_range(0, 300));
            end else begin
                gen_l = $urandom;
                gen_r = $urandom;
            end
            send_counts(gen_l, gen_r, p);
            if (n < 400 || n >= 440) idle_gap();
        end
        rx_busy = 1'b1;

        while (pose_q.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
